// ===== hw/rtl/rasy_pkg.sv =====
// ----------------------------------------------------------------------------
// rasy_pkg
// Types, widths and codes shared by the radial asymmetry accumulator.
// ----------------------------------------------------------------------------
package rasy_pkg;

  localparam int MAX_HALF_DEF = 15;

  localparam int WinW    = 5;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 5;
  localparam int PixW    = 16;
  localparam int WgtW    = 16;
  localparam int AsymW   = 64;
  localparam int StatW   = 2;

  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SQUARE_MODE = 2'd1;

  localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatW-1:0] STATUS_ZERO_BIN  = 2'd1;
  localparam logic [StatW-1:0] STATUS_EVEN_WIN  = 2'd2;
  localparam logic [StatW-1:0] STATUS_SATURATED = 2'd3;

  localparam int DivSteps = 96;

  typedef struct packed {
    logic [18:0] w;
    logic [34:0] s;
    logic [50:0] q;
    logic [3:0]  n;
  } bin_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PPP,
    ST_PWP,
    ST_PWQ,
    ST_STEP,
    ST_WRD,
    ST_WCHK,
    ST_WQW,
    ST_WSS,
    ST_WN,
    ST_WDIV,
    ST_WQT,
    ST_WSQ,
    ST_WADD,
    ST_WOUT
  } state_e;

endpackage

// ===== hw/rtl/radial_asymmetry_accumulator.sv =====
// ----------------------------------------------------------------------------
// radial_asymmetry_accumulator
// Bins weighted window pixels by radius and sums per-bin variances.
// ----------------------------------------------------------------------------
// Pixel (odd window, in range): busy while the shift-add multiplier forms |p|*|p|,
//   |p|*w and |p|^2*w in turn, then a step state; the next start waits for idle.
// Last pixel: bin walk of NBINS bins, each read and checked; empty bins are
//   skipped, filled ones take shift-add products plus a 96-step divider.
// Results come as a one-cycle strobe on valid_o; the receiver cannot stall.
// Reset: window size 31, square mode off, all bins and totals cleared.
// ----------------------------------------------------------------------------
module radial_asymmetry_accumulator import rasy_pkg::*; #(
  parameter int MaxHalf = MAX_HALF_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [PixW-1:0] pixel_i,
  input  logic [WgtW-1:0]     weight_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  output logic                valid_o,
  output logic [AsymW-1:0]    asymmetry_o,
  output logic [StatW-1:0]    status_o
);

  localparam int NBins = (MaxHalf + 1) * (MaxHalf + 2) / 2;
  localparam int IdxW  = (NBins > 1) ? $clog2(NBins) : 1;
  localparam logic [IdxW-1:0] LastBin = IdxW'(NBins - 1);

  state_e state_q, state_d;

  logic [WinW-1:0]  win_q, row_q, col_q;
  logic             sq_q;
  logic [NBins-1:0] vld_q;
  logic             rv_q;
  logic [IdxW-1:0]  addr_q, k_q;
  logic [1:0]       flags_q;
  logic [AsymW-1:0] total_q;
  logic             res_valid_q;
  logic [AsymW-1:0] asym_q;
  logic [StatW-1:0] status_q;

  bin_t             mem [NBins];
  bin_t             rd_q, ent, wd;
  logic             mem_we;

  logic [PixW-1:0]  pmag_q;
  logic             neg_q;
  logic [WgtW-1:0]  wgt_q;
  logic [127:0]     acc_q, mcand_q, mul_sum;
  logic [63:0]      mplier_q;
  logic             mul_done;
  logic [31:0]      pp_q, wp_q;
  logic [71:0]      t_q, diff;
  logic [95:0]      num_q;
  logic [39:0]      rem_q, rs;
  logic [37:0]      d_q;
  logic [6:0]       dcnt_q;
  logic [63:0]      v_q, vq;
  logic [64:0]      tsum;
  logic [34:0]      smag;
  logic [34:0]      ws;

  logic             cfg_we, start_acc, odd, last, in_rng;
  logic [WinW-1:0]  h, ar, ac, a, b;
  logic [5:0]       dr, dc;
  logic [10:0]      tri_prod;
  logic [9:0]       idx;
  logic [PixW-1:0]  pmag;

  // --------------------------------------------------------------------------
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign start_acc   = start && !busy;
  assign valid_o     = res_valid_q;
  assign asymmetry_o = asym_q;
  assign status_o    = status_q;

  assign odd = win_q[0];
  assign h   = {1'b0, win_q[WinW-1:1]};
  assign dr  = {1'b0, row_q} - {1'b0, h};
  assign dc  = {1'b0, col_q} - {1'b0, h};
  assign ar  = dr[5] ? WinW'(-dr) : dr[WinW-1:0];
  assign ac  = dc[5] ? WinW'(-dc) : dc[WinW-1:0];
  assign a   = (ar > ac) ? ar : ac;
  assign b   = (ar > ac) ? ac : ar;
  assign tri_prod = {6'b0, a} * ({6'b0, a} + 11'd1);
  assign idx      = tri_prod[10:1] + {5'b0, b};
  assign in_rng   = (int'(a) <= MaxHalf) && (int'(idx) < NBins);

  assign last = (win_q == '0) ||
                (({1'b0, row_q} + 6'd1 >= {1'b0, win_q}) &&
                 ({1'b0, col_q} + 6'd1 >= {1'b0, win_q}));

  assign pmag = pixel_i[PixW-1] ? PixW'(-pixel_i) : pixel_i;

  assign ent      = rv_q ? rd_q : '0;
  assign mul_done = (mplier_q == '0);
  assign mul_sum  = acc_q + mcand_q;
  assign smag     = ent.s[34] ? 35'(-ent.s) : ent.s;
  assign diff     = (t_q >= acc_q[71:0]) ? (t_q - acc_q[71:0]) : '0;
  assign rs       = {rem_q[38:0], num_q[95]};
  assign vq       = (num_q[95:64] != '0) ? '1 : num_q[63:0];
  assign tsum     = {1'b0, total_q} + {1'b0, v_q};

  assign ws = neg_q ? 35'(-{3'b0, wp_q}) : {3'b0, wp_q};
  always_comb begin
    wd   = ent;
    wd.w = ent.w + 19'(wgt_q);
    wd.s = ent.s + ws;
    wd.q = ent.q + 51'(acc_q[47:0]);
    wd.n = ent.n + 4'd1;
  end
  assign mem_we = (state_q == ST_PWQ) && mul_done;

  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          state_d = (odd && in_rng) ? ST_PPP : ST_STEP;
        end
      end
      ST_PPP:  if (mul_done) state_d = ST_PWP;
      ST_PWP:  if (mul_done) state_d = ST_PWQ;
      ST_PWQ:  if (mul_done) state_d = ST_STEP;
      ST_STEP: begin
        if (!last || !odd) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WRD;
        end
      end
      ST_WRD:  state_d = ST_WCHK;
      ST_WCHK: begin
        if (ent.n == '0 || ent.w == '0) begin
          state_d = ST_WADD;
        end else begin
          state_d = ST_WQW;
        end
      end
      ST_WQW:  if (mul_done) state_d = ST_WSS;
      ST_WSS:  if (mul_done) state_d = ST_WN;
      ST_WN:   if (mul_done) state_d = ST_WDIV;
      ST_WDIV: if (dcnt_q == 7'd1) state_d = ST_WQT;
      ST_WQT:  state_d = sq_q ? ST_WSQ : ST_WADD;
      ST_WSQ:  if (mul_done) state_d = ST_WADD;
      ST_WADD: state_d = (k_q == LastBin) ? ST_WOUT : ST_WRD;
      ST_WOUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= 5'd31;
      sq_q        <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      vld_q       <= '0;
      rv_q        <= 1'b0;
      flags_q     <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
      asym_q      <= '0;
      status_q    <= STATUS_OK;
      addr_q      <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      rv_q        <= vld_q[addr_q];
      if (mem_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_we) begin
            if (cfg_index_i == REG_WINDOW_SIZE) begin
              win_q   <= cfg_data_i;
              row_q   <= '0;
              col_q   <= '0;
              vld_q   <= '0;
              total_q <= '0;
              flags_q <= '0;
            end else if (cfg_index_i == REG_SQUARE_MODE) begin
              sq_q <= cfg_data_i[0];
            end
          end else if (start_acc) begin
            addr_q <= IdxW'(idx);
          end
        end
        ST_STEP: begin
          if (!last) begin
            if ({1'b0, col_q} + 6'd1 >= {1'b0, win_q}) begin
              col_q <= '0;
              row_q <= row_q + 5'd1;
            end else begin
              col_q <= col_q + 5'd1;
            end
          end else if (!odd) begin
            res_valid_q <= 1'b1;
            asym_q      <= '0;
            status_q    <= STATUS_EVEN_WIN;
            row_q       <= '0;
            col_q       <= '0;
            vld_q       <= '0;
            total_q     <= '0;
            flags_q     <= '0;
          end else begin
            k_q    <= '0;
            addr_q <= '0;
          end
        end
        ST_WCHK: begin
          if (ent.n != '0 && ent.w == '0) begin
            flags_q[0] <= 1'b1;
          end
        end
        ST_WQT: begin
          if (num_q[95:64] != '0) begin
            flags_q[1] <= 1'b1;
          end
        end
        ST_WSQ: begin
          if (mul_done && acc_q[127:80] != '0) begin
            flags_q[1] <= 1'b1;
          end
        end
        ST_WADD: begin
          if (tsum[64]) begin
            total_q    <= '1;
            flags_q[1] <= 1'b1;
          end else begin
            total_q <= tsum[63:0];
          end
          k_q    <= k_q + 1'b1;
          addr_q <= k_q + 1'b1;
        end
        ST_WOUT: begin
          res_valid_q <= 1'b1;
          asym_q      <= total_q;
          status_q    <= flags_q[1] ? STATUS_SATURATED :
                         (flags_q[0] ? STATUS_ZERO_BIN : STATUS_OK);
          row_q       <= '0;
          col_q       <= '0;
          vld_q       <= '0;
          total_q     <= '0;
          flags_q     <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= wd;
    end
    rd_q <= mem[addr_q];
  end

  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          pmag_q   <= pmag;
          neg_q    <= pixel_i[PixW-1];
          wgt_q    <= weight_i;
          acc_q    <= '0;
          mcand_q  <= 128'(pmag);
          mplier_q <= 64'(pmag);
        end
      end
      ST_PPP, ST_PWP, ST_PWQ, ST_WQW, ST_WSS, ST_WN, ST_WSQ: begin
        if (!mul_done) begin
          if (mplier_q[0]) begin
            acc_q <= mul_sum;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end else begin
          case (state_q)
            ST_PPP: begin
              pp_q     <= acc_q[31:0];
              acc_q    <= '0;
              mcand_q  <= 128'(wgt_q);
              mplier_q <= 64'(pmag_q);
            end
            ST_PWP: begin
              wp_q     <= acc_q[31:0];
              acc_q    <= '0;
              mcand_q  <= 128'(pp_q);
              mplier_q <= 64'(wgt_q);
            end
            ST_WQW: begin
              t_q      <= acc_q[71:0];
              acc_q    <= '0;
              mcand_q  <= 128'(smag);
              mplier_q <= 64'(smag);
            end
            ST_WSS: begin
              acc_q    <= '0;
              mcand_q  <= 128'(diff);
              mplier_q <= 64'(ent.n);
            end
            ST_WN: begin
              num_q  <= {acc_q[79:0], 16'b0};
              rem_q  <= '0;
              d_q    <= 38'(ent.w) * 38'(ent.w);
              dcnt_q <= 7'(DivSteps);
            end
            ST_WSQ: begin
              v_q <= (acc_q[127:80] != '0) ? '1 : acc_q[79:16];
            end
            default: begin
            end
          endcase
        end
      end
      ST_WCHK: begin
        v_q      <= '0;
        acc_q    <= '0;
        mcand_q  <= 128'(ent.q);
        mplier_q <= 64'(ent.w);
      end
      ST_WDIV: begin
        if (rs >= {2'b0, d_q}) begin
          rem_q <= rs - {2'b0, d_q};
          num_q <= {num_q[94:0], 1'b1};
        end else begin
          rem_q <= rs;
          num_q <= {num_q[94:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 7'd1;
      end
      ST_WQT: begin
        v_q      <= vq;
        acc_q    <= '0;
        mcand_q  <= 128'(vq);
        mplier_q <= vq;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WDIV) |-> (d_q != '0))
    else $error("divide by zero weight");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> busy)
    else $error("accepted transaction did not raise busy");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WCHK) |-> (int'(k_q) < NBins))
    else $error("bin walk out of range");

endmodule
